// ===== rtl/core/mrtu_pkg.sv =====
package mrtu_pkg;

    // Parser phases; codes 3 and 7 are unused and fall back to waiting
    typedef enum logic [2:0] {
        PH_WAIT  = 3'd0,
        PH_FUNC  = 3'd1,
        PH_ADDR  = 3'd2,
        PH_COUNT = 3'd4,
        PH_CRC   = 3'd5,
        PH_VALUE = 3'd6
    } mrtu_phase_t;

    // Word kinds on the input channel
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_SLAVE_ADDR  = 2'd0;
    localparam logic [1:0] CFG_LEGACY_MODE = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

    localparam logic [7:0] SLAVE_ADDR_RST = 8'd1;
    localparam logic [7:0] TIMEOUT_RST    = 8'd5;

    // Function codes
    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_READ_INPUT   = 8'h04;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_BAD_CRC      = 8'h08;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef struct packed {
        logic [7:0] slave_address;
        logic       legacy_address_mode;
        logic [7:0] timeout_ticks;
    } mrtu_cfg_t;

    typedef struct packed {
        logic [7:0]  func_code;
        logic [15:0] register_address;
        logic [15:0] data_word;
    } mrtu_result_t;

    // CRC-16/MODBUS update by one byte, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/mrtu_cfg_regs.sv =====
module mrtu_cfg_regs
    import mrtu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    output mrtu_cfg_t  cfg
);

    mrtu_cfg_t cfg_reg;
    mrtu_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLAVE_ADDR:  cfg_next.slave_address       = cfg_wdata;
                CFG_LEGACY_MODE: cfg_next.legacy_address_mode = cfg_wdata[0];
                CFG_TIMEOUT:     cfg_next.timeout_ticks       = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address       <= SLAVE_ADDR_RST;
            cfg_reg.legacy_address_mode <= 1'b0;
            cfg_reg.timeout_ticks       <= TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/mrtu_parse_core.sv =====
module mrtu_parse_core
    import mrtu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  mrtu_cfg_t    cfg,
    input  logic         accept,
    input  logic         operation,
    input  logic [7:0]   rx_byte,
    output logic         res_valid,
    output mrtu_result_t res
);

    mrtu_phase_t phase_reg, phase_next;
    logic        fbc_reg, fbc_next;
    logic [7:0]  func_reg, func_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] value_reg, value_next;
    logic [7:0]  rcrc_lo_reg, rcrc_lo_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  idle_reg, idle_next;

    logic [15:0] crc_fed;
    logic [7:0]  idle_inc;
    logic [15:0] addr_shift;

    assign crc_fed    = crc16_byte(crc_reg, rx_byte);
    assign idle_inc   = idle_reg + 8'd1;
    assign addr_shift = fbc_reg ? {addr_reg[7:0], rx_byte} : {8'h00, rx_byte};

    always_comb
    begin
        phase_next   = phase_reg;
        fbc_next     = fbc_reg;
        func_next    = func_reg;
        addr_next    = addr_reg;
        count_next   = count_reg;
        value_next   = value_reg;
        rcrc_lo_next = rcrc_lo_reg;
        crc_next     = crc_reg;
        idle_next    = idle_reg;
        res_valid    = 1'b0;
        res.func_code        = func_reg;
        res.register_address = addr_reg;
        res.data_word        = (func_reg == FC_WRITE_SINGLE) ? value_reg : count_reg;

        if (accept)
        begin
            if (operation == OP_TICK)
            begin
                idle_next = idle_inc;
                if (idle_inc > cfg.timeout_ticks)
                begin
                    phase_next = PH_WAIT;
                    fbc_next   = 1'b0;
                    idle_next  = 8'd0;
                end
            end
            else
            begin
                idle_next = 8'd0;
                case (phase_reg)
                    PH_WAIT:
                    begin
                        if (rx_byte == cfg.slave_address)
                        begin
                            phase_next   = PH_FUNC;
                            addr_next    = 16'd0;
                            rcrc_lo_next = 8'd0;
                            fbc_next     = 1'b0;
                            crc_next     = crc16_byte(CRC_INIT, rx_byte);
                        end
                    end
                    PH_FUNC:
                    begin
                        func_next = rx_byte;
                        if (rx_byte == FC_READ_INPUT || rx_byte == FC_WRITE_SINGLE ||
                            rx_byte == FC_READ_HOLDING)
                        begin
                            phase_next = PH_ADDR;
                            fbc_next   = 1'b0;
                            crc_next   = crc_fed;
                        end
                        else
                        begin
                            phase_next   = PH_WAIT;
                            func_next    = 8'd0;
                            addr_next    = 16'd0;
                            count_next   = 16'd0;
                            rcrc_lo_next = 8'd0;
                        end
                    end
                    PH_ADDR:
                    begin
                        addr_next = cfg.legacy_address_mode ? 16'd0 : addr_shift;
                        crc_next  = crc_fed;
                        if (!fbc_reg)
                        begin
                            fbc_next = 1'b1;
                        end
                        else
                        begin
                            fbc_next   = 1'b0;
                            count_next = 16'd0;
                            if (func_reg == FC_READ_INPUT)
                                phase_next = PH_COUNT;
                            else if (func_reg == FC_WRITE_SINGLE)
                                phase_next = PH_VALUE;
                            else
                            begin
                                // read holding: drop after the address
                                phase_next   = PH_WAIT;
                                func_next    = 8'd0;
                                addr_next    = 16'd0;
                                rcrc_lo_next = 8'd0;
                            end
                        end
                    end
                    PH_COUNT:
                    begin
                        count_next = fbc_reg ? {count_reg[7:0], rx_byte} : {8'h00, rx_byte};
                        crc_next   = crc_fed;
                        fbc_next   = !fbc_reg;
                        if (fbc_reg)
                            phase_next = PH_CRC;
                    end
                    PH_VALUE:
                    begin
                        value_next = fbc_reg ? {value_reg[7:0], rx_byte} : {8'h00, rx_byte};
                        crc_next   = crc_fed;
                        fbc_next   = !fbc_reg;
                        if (fbc_reg)
                            phase_next = PH_CRC;
                    end
                    PH_CRC:
                    begin
                        if (!fbc_reg)
                        begin
                            rcrc_lo_next = rx_byte;
                            fbc_next     = 1'b1;
                        end
                        else
                        begin
                            fbc_next   = 1'b0;
                            phase_next = PH_WAIT;
                            if ({rx_byte, rcrc_lo_reg} == crc_reg)
                            begin
                                res_valid    = 1'b1;
                                rcrc_lo_next = rcrc_lo_reg;
                            end
                            else
                            begin
                                func_next    = FC_BAD_CRC;
                                addr_next    = 16'd0;
                                count_next   = 16'd0;
                                rcrc_lo_next = 8'd0;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_WAIT;
                        fbc_next   = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            fbc_reg     <= 1'b0;
            func_reg    <= 8'd0;
            addr_reg    <= 16'd0;
            count_reg   <= 16'd0;
            value_reg   <= 16'd0;
            rcrc_lo_reg <= 8'd0;
            crc_reg     <= CRC_INIT;
            idle_reg    <= 8'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            fbc_reg     <= fbc_next;
            func_reg    <= func_next;
            addr_reg    <= addr_next;
            count_reg   <= count_next;
            value_reg   <= value_next;
            rcrc_lo_reg <= rcrc_lo_next;
            crc_reg     <= crc_next;
            idle_reg    <= idle_next;
        end
    end

endmodule

// ===== rtl/core/mrtu_out_queue.sv =====
module mrtu_out_queue
    import mrtu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  mrtu_result_t push_data,
    output logic         has_room,
    output logic         out_valid,
    input  logic         out_ready,
    output mrtu_result_t out_data
);

    mrtu_result_t entry_mem [2];
    logic [1:0]   count_reg, count_next;
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic         pop;

    assign out_valid = (count_reg != 2'd0);
    assign has_room  = !count_reg[1];
    assign pop       = out_valid && out_ready;
    assign out_data  = entry_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

// ===== rtl/core/modbus_rtu_request_parser_unit.sv =====
// Modbus RTU request parser (slave side). Each input word is either a received
// byte (operation 0) or a timer tick (operation 1). A frame starts at a byte equal
// to slave_address and carries function, big-endian register address, big-endian
// count (0x04) or value (0x06) and a little-endian CRC-16/MODBUS. A frame whose
// CRC matches yields one output word; function 0x03 is dropped after its address,
// other functions abort at once, and more than timeout_ticks ticks without a byte
// restart the search for an address. One input word is taken per clock while
// the queue has room (it stalls only when both entries hold a stalled output);
// parser state and byte-wide CRC update are registered per word, and a result
// word enters the two-entry queue, seen in the cycle after the closing CRC byte.
// The user must write configuration registers via cfg_we/cfg_index/cfg_wdata
// (0 slave address, 1 legacy address mode, 2 timeout) only while idle; unchecked.
module modbus_rtu_request_parser_unit
    import mrtu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  func_code,
    output logic [15:0] register_address,
    output logic [15:0] data_word
);

    mrtu_cfg_t    cfg;
    mrtu_result_t res;
    mrtu_result_t q_data;
    logic         res_valid;
    logic         has_room;
    logic         in_fire;

    // word accepted whenever the result queue has a free entry
    assign in_ready = has_room;
    assign in_fire  = in_valid && has_room;

    mrtu_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mrtu_parse_core u_parse_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (in_fire),
        .operation (operation),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    mrtu_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .has_room  (has_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (q_data)
    );

    assign func_code        = q_data.func_code;
    assign register_address = q_data.register_address;
    assign data_word        = q_data.data_word;

endmodule
